### rtl/assert_macros.svh
// Assertion macros used by the RTL top level.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tsr_pkg.sv
// Shared types and constants for the TCP segment reorder block.
// No dependencies.
`timescale 1ns / 1ps

package tsr_pkg;

    localparam int SEQ_W           = 32;
    localparam int LEN_W           = 11;
    localparam int HANDLE_W        = 16;
    localparam int SLOTS_DEF       = 32;
    localparam int HANDLE_BITS_DEF = 16;

    localparam logic [LEN_W-1:0] MAX_LEN_RST = LEN_W'(1024);

    typedef enum logic [2:0] {
        K_DELIVER  = 3'd0,
        K_RELEASE  = 3'd1,
        K_STORED   = 3'd2,
        K_DUP      = 3'd3,
        K_STALE    = 3'd4,
        K_OVERFLOW = 3'd5,
        K_BADLEN   = 3'd6
    } t_kind;

    typedef struct packed {
        logic [SEQ_W-1:0]    seg_seq;
        logic [LEN_W-1:0]    seg_len;
        logic [HANDLE_W-1:0] buf_handle;
    } t_in_word;

    typedef struct packed {
        t_kind               kind;
        logic [HANDLE_W-1:0] out_handle;
        logic [LEN_W-1:0]    byte_offset;
        logic [LEN_W-1:0]    out_len;
        logic [SEQ_W-1:0]    next_expected;
        logic                last;
    } t_out_word;

    // controller -> datapath
    typedef struct packed {
        logic  load_in;
        logic  commit;
        t_kind kind;
        logic  release_step;
        logic  push;
        logic  last;
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic bad_len;
        logic in_order;
        logic ahead;
        logic dup_hit;
        logic free_any;
        logic end_ahead;
        logic rel_hit;
        logic out_free;
    } t_dp_sts;

endpackage

### rtl/tcp_segment_reorder.sv
// Top level of the TCP segment reorder block: controller plus datapath.
// Depends on tsr_pkg, tsr_ctrl, tsr_dpath and assert_macros.svh.
//
//  channel | direction | handshake               | word
//  in      | input     | i_in_valid / o_in_ready | t_in_word
//  out     | output    | o_out_valid/i_out_ready | t_out_word
//  cfg     | input     | i_cfg_we                | i_cfg_wdata (max_length)
//
// A segment is latched on acceptance, then classified; its classification word
// moves to the output register first, then one release word per released slot,
// and the next segment is taken in the cycle the final word moves to the output
// register. Release search is a parallel compare over all slots.
// Reset clears expected sequence, sync and slot valid bits at once.
// A stalled output holds the FSM; no input is taken until the last word moves.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcp_segment_reorder
    import tsr_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_word         i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_word        o_out_word,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata
);

    t_ctl_cmd w_cmd;
    t_dp_sts  w_sts;

    tsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tsr_dpath #(
        .SLOTS       (SLOTS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

    `ASSERT_NOW(a_push_needs_room, w_cmd.push, w_sts.out_free, "push into full output")
    `ASSERT_NOW(a_release_with_push, w_cmd.release_step, w_cmd.push && !w_cmd.last, "release without push")
    `ASSERT_NEXT(a_no_back_to_back, i_in_valid && o_in_ready, !o_in_ready, "input taken while busy")

endmodule

### rtl/tsr_ctrl.sv
// Sequencing FSM for the segment reorder block: classify, then emit and release.
// Depends on tsr_pkg.
`timescale 1ns / 1ps

module tsr_ctrl
    import tsr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_sts  i_sts,
    output t_ctl_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EVAL  = 3'b010,
        S_CHAIN = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_chain, n_chain;
    logic   w_rel;
    t_kind  w_kind;

    // classification priority
    always_comb begin
        priority if (i_sts.bad_len) begin
            w_kind = K_BADLEN;
        end else if (i_sts.in_order) begin
            w_kind = K_DELIVER;
        end else if (i_sts.ahead) begin
            priority if (i_sts.dup_hit) begin
                w_kind = K_DUP;
            end else if (!i_sts.free_any) begin
                w_kind = K_OVERFLOW;
            end else begin
                w_kind = K_STORED;
            end
        end else if (i_sts.end_ahead) begin
            w_kind = K_DELIVER;
        end else begin
            w_kind = K_STALE;
        end
    end

    assign w_rel = r_chain && i_sts.rel_hit;

    always_comb begin
        n_state    = r_state;
        n_chain    = r_chain;
        o_cmd      = '0;
        o_cmd.kind = w_kind;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.commit = 1'b1;
                n_chain      = (w_kind == K_DELIVER);
                n_state      = S_CHAIN;
            end
            S_CHAIN: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    o_cmd.last = !w_rel;
                    if (w_rel) begin
                        o_cmd.release_step = 1'b1;
                    end else begin
                        // last word goes out; next segment may enter now
                        o_in_ready    = 1'b1;
                        o_cmd.load_in = i_in_valid;
                        n_state       = i_in_valid ? S_EVAL : S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chain <= n_chain;
        end
    end

endmodule

### rtl/tsr_dpath.sv
// Datapath: input latch, expected sequence, slot table with parallel compare,
// pending result and output register. Depends on tsr_pkg.
`timescale 1ns / 1ps

module tsr_dpath
    import tsr_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_in_word         i_in_word,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata,
    input  t_ctl_cmd         i_cmd,
    output t_dp_sts          o_sts,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output t_out_word        o_out_word
);

    localparam int HW      = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int SLOT_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [LEN_W-1:0] r_max_len;
    t_in_word         r_in;
    logic [SEQ_W-1:0] r_exp;
    logic             r_sync;

    logic [SLOTS-1:0] r_used;
    logic [SEQ_W-1:0] r_sseq [SLOTS];
    logic [LEN_W-1:0] r_slen [SLOTS];
    logic [HW-1:0]    r_shdl [SLOTS];

    t_out_word r_pend;
    t_out_word r_out;
    logic      r_out_valid;

    logic [HW-1:0]      w_hdl;
    logic [SEQ_W-1:0]   w_exp_eff, w_diff, w_end, w_end_diff;
    logic [SLOTS-1:0]   w_dup_vec, w_rel_vec;
    logic [SLOT_IW-1:0] w_free_idx, w_rel_idx;
    logic               w_out_free;
    logic [LEN_W-1:0]   w_rel_len;
    logic [SEQ_W-1:0]   w_rel_exp;
    t_out_word          w_commit_word, w_rel_word, w_push_word;

    assign w_hdl      = r_in.buf_handle[HW-1:0];
    assign w_exp_eff  = r_sync ? r_exp : r_in.seg_seq;
    assign w_diff     = r_in.seg_seq - w_exp_eff;
    assign w_end      = r_in.seg_seq + SEQ_W'(r_in.seg_len);
    assign w_end_diff = w_end - w_exp_eff;
    assign w_out_free = !r_out_valid || i_out_ready;

    // parallel slot compares, lowest index wins
    always_comb begin
        w_free_idx = '0;
        w_rel_idx  = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            w_dup_vec[i] = r_used[i] && (r_sseq[i] == r_in.seg_seq);
            w_rel_vec[i] = r_used[i] && (r_sseq[i] == r_exp);
            if (!r_used[i]) begin
                w_free_idx = SLOT_IW'(i);
            end
            if (w_rel_vec[i]) begin
                w_rel_idx = SLOT_IW'(i);
            end
        end
    end

    assign w_rel_len = r_slen[w_rel_idx];
    assign w_rel_exp = r_exp + SEQ_W'(w_rel_len);

    always_comb begin
        o_sts.bad_len   = (r_in.seg_len == '0) || (r_in.seg_len > r_max_len);
        o_sts.in_order  = (w_diff == '0);
        o_sts.ahead     = (w_diff != '0) && !w_diff[SEQ_W-1];
        o_sts.dup_hit   = |w_dup_vec;
        o_sts.free_any  = !(&r_used);
        o_sts.end_ahead = (w_end_diff != '0) && !w_end_diff[SEQ_W-1];
        o_sts.rel_hit   = |w_rel_vec;
        o_sts.out_free  = w_out_free;
    end

    // result words for classification, release and push
    always_comb begin
        w_commit_word               = '0;
        w_commit_word.kind          = i_cmd.kind;
        w_commit_word.out_handle    = HANDLE_W'(w_hdl);
        w_commit_word.next_expected = w_exp_eff;
        unique case (i_cmd.kind)
            K_DELIVER: begin
                // in-order case gives offset 0 and full length here too
                w_commit_word.byte_offset   = LEN_W'(w_exp_eff - r_in.seg_seq);
                w_commit_word.out_len       = LEN_W'(w_end_diff);
                w_commit_word.next_expected = w_end;
            end
            K_BADLEN: begin
                w_commit_word.next_expected = r_exp;
            end
            default: begin
                w_commit_word.next_expected = w_exp_eff;
            end
        endcase

        w_rel_word               = '0;
        w_rel_word.kind          = K_RELEASE;
        w_rel_word.out_handle    = HANDLE_W'(r_shdl[w_rel_idx]);
        w_rel_word.out_len       = w_rel_len;
        w_rel_word.next_expected = w_rel_exp;

        w_push_word      = r_pend;
        w_push_word.last = i_cmd.last;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= MAX_LEN_RST;
            r_exp       <= '0;
            r_sync      <= 1'b0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
            if (i_cmd.commit && i_cmd.kind != K_BADLEN) begin
                r_sync <= (i_cmd.kind != K_OVERFLOW);
                r_exp  <= (i_cmd.kind == K_DELIVER) ? w_end : w_exp_eff;
                if (i_cmd.kind == K_OVERFLOW) begin
                    r_used <= '0;
                end
                if (i_cmd.kind == K_STORED) begin
                    r_used[w_free_idx] <= 1'b1;
                end
            end
            if (i_cmd.release_step) begin
                r_used[w_rel_idx] <= 1'b0;
                r_exp             <= w_rel_exp;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_word;
        end
        if (i_cmd.commit) begin
            r_pend <= w_commit_word;
            if (i_cmd.kind == K_STORED) begin
                r_sseq[w_free_idx] <= r_in.seg_seq;
                r_slen[w_free_idx] <= r_in.seg_len;
                r_shdl[w_free_idx] <= w_hdl;
            end
        end
        if (i_cmd.release_step) begin
            r_pend <= w_rel_word;
        end
        if (i_cmd.push) begin
            r_out <= w_push_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

### tb/tcp_segment_reorder_test.sv
// Testbench for tcp_segment_reorder: directed and random segment streams with a scoreboard.
// The scoreboard class predicts the result words in order. Depends on tsr_pkg and the RTL.
`timescale 1ns / 1ps

module tcp_segment_reorder_test;
    import tsr_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int HOLD_CYCLES  = 250;
    localparam int PHASE_SEGS   = 90;

    class reorder_scoreboard;
        logic [LEN_W-1:0]    max_len;
        logic [SEQ_W-1:0]    next_seq;
        bit                  synced;
        bit                  slot_full [SLOTS_DEF];
        logic [SEQ_W-1:0]    slot_seq [SLOTS_DEF];
        logic [LEN_W-1:0]    slot_len [SLOTS_DEF];
        logic [HANDLE_W-1:0] slot_handle [SLOTS_DEF];
        t_out_word           expected_words [$];
        t_out_word           held;
        bit                  have_held;
        int                  errors;

        function new();
            max_len   = MAX_LEN_RST;
            next_seq  = '0;
            synced    = 1'b0;
            have_held = 1'b0;
            errors    = 0;
            foreach (slot_full[i]) slot_full[i] = 1'b0;
        endfunction

        // a difference of exactly 2^31 counts as behind
        function bit seq_after(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
            logic [SEQ_W-1:0] d;
            d = a - b;
            return (d != '0) && !d[SEQ_W-1];
        endfunction

        // one word is held back so the final one of a segment can get its last flag
        function void add_word(t_kind k, logic [HANDLE_W-1:0] h, logic [LEN_W-1:0] offs,
                               logic [LEN_W-1:0] len);
            if (have_held) expected_words.push_back(held);
            held = '{kind: k, out_handle: h, byte_offset: offs, out_len: len,
                     next_expected: next_seq, last: 1'b0};
            have_held = 1'b1;
        endfunction

        function void release_stored();
            bit found;
            found = 1'b1;
            while (found) begin
                found = 1'b0;
                for (int i = 0; i < SLOTS_DEF && !found; i++) begin
                    if (slot_full[i] && slot_seq[i] == next_seq) begin
                        slot_full[i] = 1'b0;
                        next_seq += SEQ_W'(slot_len[i]);
                        add_word(K_RELEASE, slot_handle[i], '0, slot_len[i]);
                        found = 1'b1;
                    end
                end
            end
        endfunction

        function void note_segment(t_in_word w);
            logic [SEQ_W-1:0] seg_end, offs, new_len;
            int dup_at, free_at;
            if (w.seg_len == '0 || w.seg_len > max_len) begin
                add_word(K_BADLEN, w.buf_handle, '0, '0);
            end else begin
                if (!synced) begin
                    next_seq = w.seg_seq;
                    synced   = 1'b1;
                end
                if (w.seg_seq == next_seq) begin
                    next_seq += SEQ_W'(w.seg_len);
                    add_word(K_DELIVER, w.buf_handle, '0, w.seg_len);
                    release_stored();
                end else if (seq_after(w.seg_seq, next_seq)) begin
                    dup_at  = -1;
                    free_at = -1;
                    for (int i = 0; i < SLOTS_DEF; i++) begin
                        if (slot_full[i] && slot_seq[i] == w.seg_seq && dup_at < 0) dup_at = i;
                        if (!slot_full[i] && free_at < 0) free_at = i;
                    end
                    if (dup_at >= 0) begin
                        add_word(K_DUP, w.buf_handle, '0, '0);
                    end else if (free_at < 0) begin
                        foreach (slot_full[i]) slot_full[i] = 1'b0;
                        synced = 1'b0;
                        add_word(K_OVERFLOW, w.buf_handle, '0, '0);
                    end else begin
                        slot_full[free_at]   = 1'b1;
                        slot_seq[free_at]    = w.seg_seq;
                        slot_len[free_at]    = w.seg_len;
                        slot_handle[free_at] = w.buf_handle;
                        add_word(K_STORED, w.buf_handle, '0, '0);
                    end
                end else begin
                    seg_end = w.seg_seq + SEQ_W'(w.seg_len);
                    if (seq_after(seg_end, next_seq)) begin
                        // overlaps old data: skip the bytes already delivered
                        offs     = next_seq - w.seg_seq;
                        new_len  = seg_end - next_seq;
                        next_seq = seg_end;
                        add_word(K_DELIVER, w.buf_handle, offs[LEN_W-1:0], new_len[LEN_W-1:0]);
                        release_stored();
                    end else begin
                        add_word(K_STALE, w.buf_handle, '0, '0);
                    end
                end
            end
            held.last = 1'b1;
            expected_words.push_back(held);
            have_held = 1'b0;
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            bit        bad;
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: kind %0d handle %h next %h",
                             got.kind, got.out_handle, got.next_expected);
                return;
            end
            want = expected_words.pop_front();
            bad = (got.kind !== want.kind) || (got.out_handle !== want.out_handle) ||
                  (got.byte_offset !== want.byte_offset) || (got.out_len !== want.out_len) ||
                  (got.next_expected !== want.next_expected) || (got.last !== want.last);
            if (bad) begin
                errors++;
                if (errors <= 10) begin
                    $display("exp kind %0d hdl %h off %0d len %0d next %h last %b",
                             want.kind, want.out_handle, want.byte_offset, want.out_len,
                             want.next_expected, want.last);
                    $display("got kind %0d hdl %h off %0d len %0d next %h last %b",
                             got.kind, got.out_handle, got.byte_offset, got.out_len,
                             got.next_expected, got.last);
                end
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    t_in_word         in_word;
    logic             out_valid;
    logic             out_ready;
    t_out_word        out_word;
    logic             cfg_we;
    logic [LEN_W-1:0] cfg_wdata;

    reorder_scoreboard sb;
    bit gaps_on;
    bit hold_req;
    int hold_left;
    int hold_mark;
    int segs_sent;
    int cycles;

    tcp_segment_reorder u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("tcp_segment_reorder: mismatch");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_word(out_word);
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end else begin
                out_ready <= !(gaps_on && $urandom_range(99) < 9);
            end
        end
    end

    // returns right after the accepting edge so valid can stay high into the next word
    task automatic send_seg(input logic [SEQ_W-1:0] s, input logic [LEN_W-1:0] l,
                            input logic [HANDLE_W-1:0] h);
        t_in_word w;
        w = '{seg_seq: s, seg_len: l, buf_handle: h};
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < 9) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        sb.note_segment(w);
        segs_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_max_length(input logic [LEN_W-1:0] v);
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.max_len = v;
    endtask

    function automatic logic [LEN_W-1:0] rand_len();
        if (sb.max_len == '0) return LEN_W'(1);
        return LEN_W'($urandom_range(1, sb.max_len));
    endfunction

    // mostly contiguous streams, usually shuffled; some overrun the slots on purpose
    task automatic run_burst();
        logic [SEQ_W-1:0] seqs [48];
        logic [LEN_W-1:0] lens [48];
        logic [SEQ_W-1:0] tseq;
        logic [LEN_W-1:0] tlen;
        int n, lo, j, k, pick;
        pick = $urandom_range(99);
        if (pick < 62) begin
            lo = (pick < 55) ? 0 : 1;
            n  = (pick < 55) ? $urandom_range(2, 12) : $urandom_range(33, 36);
            tseq = sb.synced ? sb.next_seq : SEQ_W'($urandom());
            for (int i = 0; i < n; i++) begin
                seqs[i] = tseq;
                lens[i] = rand_len();
                tseq += SEQ_W'(lens[i]);
            end
            if (pick >= 10) begin
                for (int i = n - 1; i > lo; i--) begin
                    j = $urandom_range(lo, i);
                    tseq = seqs[i]; seqs[i] = seqs[j]; seqs[j] = tseq;
                    tlen = lens[i]; lens[i] = lens[j]; lens[j] = tlen;
                end
            end
            for (int i = lo; i < n; i++)
                send_seg(seqs[i], lens[i], HANDLE_W'($urandom()));
            if (lo == 1) begin
                send_seg(seqs[0], lens[0], HANDLE_W'($urandom()));
            end else if ($urandom_range(3) == 0) begin
                k = $urandom_range(0, n - 1);
                send_seg(seqs[k], lens[k], HANDLE_W'($urandom()));
            end
        end else if (pick < 80) begin
            // retransmit reaching back over delivered bytes, partly or wholly
            tlen = rand_len();
            if ($urandom_range(3) == 0)
                tseq = sb.next_seq - SEQ_W'($urandom_range(tlen, 5000));
            else
                tseq = sb.next_seq - SEQ_W'($urandom_range(0, tlen));
            send_seg(tseq, tlen, HANDLE_W'($urandom()));
        end else if (pick < 92) begin
            send_seg(SEQ_W'($urandom()), LEN_W'($urandom_range(0, 2047)),
                     HANDLE_W'($urandom()));
        end else begin
            if (sb.max_len == 11'd2047 || $urandom_range(1) == 0)
                tlen = '0;
            else
                tlen = LEN_W'($urandom_range(sb.max_len + 1, 2047));
            send_seg(sb.next_seq, tlen, HANDLE_W'($urandom()));
        end
    endtask

    task automatic run_phase(input logic [LEN_W-1:0] max_len, input int seg_count);
        int stop_at;
        set_max_length(max_len);
        stop_at = segs_sent + seg_count;
        while (segs_sent < stop_at) run_burst();
    endtask

    initial begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        gaps_on   = 1'b1;
        hold_req  = 1'b0;
        hold_left = 0;
        hold_mark = 0;
        segs_sent = 0;
        cycles    = 0;
        sb = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: bad lengths before sync, sync across the wrap, store and release
        send_seg(32'h0000_0000, 11'd0,    16'hFFFF);
        send_seg(32'hFFFF_FFFF, 11'd1025, 16'h0000);
        send_seg(32'hFFFF_FF00, 11'd1024, 16'h0001);
        send_seg(32'h0000_0500, 11'h100,  16'h0002);
        send_seg(32'h0000_0500, 11'h080,  16'h0003);
        send_seg(32'h0000_0400, 11'h100,  16'h0004);
        send_seg(32'h0000_0300, 11'h100,  16'h0005);
        send_seg(32'h0000_0100, 11'h100,  16'h0006);
        send_seg(32'h0000_05F0, 11'h020,  16'h0007);
        // ends exactly at the expected sequence: nothing new
        send_seg(32'h0000_0500, 11'h110,  16'h0008);
        // exactly half the sequence space away counts as behind
        send_seg(32'h8000_0610, 11'd1,    16'h0009);
        send_seg(32'h8000_060F, 11'd1,    16'h000A);
        send_seg(32'h0000_0600, 11'd1024, 16'h000B);
        set_max_length(11'd2047);
        send_seg(32'h0000_0A00, 11'd2047, 16'hAAAA);
        send_seg(32'h0000_0A01, 11'd2047, 16'h5555);
        set_max_length(11'd1);
        send_seg(32'h0000_1200, 11'd1,    16'h00FF);
        send_seg(32'h0000_1201, 11'd2,    16'hFF00);
        set_max_length(11'd0);
        send_seg(32'h0000_1201, 11'd1,    16'h1234);

        run_phase(11'd2047, PHASE_SEGS);
        gaps_on = 1'b0;
        run_phase(11'd1024, PHASE_SEGS);
        gaps_on = 1'b1;
        // long receiver hold-off once the sender is busy again
        hold_mark = segs_sent + 20;
        fork
            begin
                wait (segs_sent >= hold_mark);
                hold_req = 1'b1;
            end
        join_none
        run_phase(LEN_W'($urandom_range(1, 48)), PHASE_SEGS);
        run_phase(LEN_W'($urandom_range(1, 2047)), PHASE_SEGS);

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.errors == 0)
            $display("tcp_segment_reorder: match");
        else
            $display("tcp_segment_reorder: mismatch");
        $finish;
    end

endmodule

### tcp_segment_reorder.f
+incdir+rtl
rtl/tsr_pkg.sv
rtl/tsr_ctrl.sv
rtl/tsr_dpath.sv
rtl/tcp_segment_reorder.sv
tb/tcp_segment_reorder_test.sv
